@@ design/bale_pkg.sv @@
// Package: shared constants, codes and request/result types of the array list engine.
package bale_pkg;

  // Built size of the list.
  localparam int CAPACITY    = 16;
  localparam int ENTRY_WIDTH = 32;

  // Fixed field widths.
  localparam int OP_W    = 3;
  localparam int POS_W   = 4;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 5;
  localparam int LIMIT_W = 5;

  // Derived widths.
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CMP_A  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CMP_W  = (CMP_A > LIMIT_W) ? CMP_A : LIMIT_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_INSERT = 3'd4,
    OP_REMOVE = 3'd5
  } bale_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } bale_status_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] entry_in;
  } bale_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] entry_out;
    logic [FILL_W-1:0] fill_count;
  } bale_rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic exec;
  } bale_cmd_t;

endpackage

@@ design/bounded_array_list_engine_unit.sv @@
// Top level: bounded array list engine, controller plus shift-cell datapath.
//
//   Channel | Ports                         | Moves
//   --------+-------------------------------+-----------------------------------
//   in      | in_valid, in_stall, in_req    | request: opcode, position, entry
//   out     | out_valid, out_stall, out_rsp | result: status, entry, fill count
//   cfg     | cfg_we, cfg_wdata             | list limit write, clears count
//
// Each request is first captured, then executed in the shift-register cells;
// a new request is taken only once the current one has executed.
// Insert and remove move every cell at once, so all opcodes cost the same.
// Reset (rst_n low, synchronous) empties the list and sets the limit to 16.
// A stalled result holds the execute step; the next request is still captured.
module bounded_array_list_engine_unit
  import bale_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bale_req_t          in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output bale_rsp_t          out_rsp,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  bale_cmd_t cmd;

  bale_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bale_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .cmd       (cmd),
    .out_rsp   (out_rsp)
  );

endmodule

@@ design/bale_ctrl.sv @@
// Controller: request sequencing and result handshake state machine.
module bale_ctrl
  import bale_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output bale_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } bale_state_t;

  bale_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  // Result slot can take a new result this cycle.
  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.exec    = (state_r == S_EXEC) && out_free;
  assign out_valid   = out_valid_r;

  // Advance the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/bale_dpath.sv @@
// Datapath: shift-register cells, count, limit register and result register.
module bale_dpath
  import bale_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  bale_req_t          in_req,
  input  bale_cmd_t          cmd,
  output bale_rsp_t          out_rsp
);

  logic [ENTRY_WIDTH-1:0] cell_r   [CAPACITY];
  logic [ENTRY_WIDTH-1:0] cell_nxt [CAPACITY];
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [LIMIT_W-1:0]     limit_r;
  bale_req_t              req_r;
  bale_rsp_t              rsp_r;

  logic [CMP_W-1:0]       pos_x, cnt_x, lim_x, raw_lim_x, wr_idx, rd_idx;
  logic [ENTRY_WIDTH-1:0] data_m, rd_data;
  logic [STAT_W-1:0]      status;
  logic                   wr_en, sh_up, sh_dn, rd_en;

  // Widen operands to one compare width; clamp the limit to the built size.
  assign pos_x     = CMP_W'(req_r.position);
  assign cnt_x     = CMP_W'(count_r);
  assign raw_lim_x = CMP_W'(limit_r);
  assign lim_x     = (raw_lim_x > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : raw_lim_x;
  assign data_m    = ENTRY_WIDTH'(req_r.entry_in);

  // Decode the request.
  always_comb begin
    status    = ST_OK;
    wr_en     = 1'b0;
    sh_up     = 1'b0;
    sh_dn     = 1'b0;
    rd_en     = 1'b0;
    wr_idx    = pos_x;
    rd_idx    = pos_x;
    count_nxt = count_r;
    case (req_r.opcode)
      OP_PUSH: begin
        if (cnt_x >= lim_x) begin
          status = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_idx    = cnt_x;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = cnt_x - CMP_W'(1);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) status = ST_BADPOS;
        else rd_en = 1'b1;
      end
      OP_WRITE: begin
        if (pos_x >= lim_x) status = ST_BADPOS;
        else wr_en = 1'b1;
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status = ST_BADPOS;
        end else if (cnt_x >= lim_x) begin
          status = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          sh_up     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status = ST_BADPOS;
        end else begin
          sh_dn     = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: status = ST_BADPOS;
    endcase
  end

  // Select the entry to return; index is in range whenever it is used.
  assign rd_data = rd_en ? cell_r[rd_idx[IDX_W-1:0]] : '0;

  // Per-cell next value: load, shift up, shift down or hold.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (wr_en && (CMP_W'(i) == wr_idx)) begin
        cell_nxt[i] = data_m;
      end else if (sh_up && (i > 0) && (CMP_W'(i) > pos_x) && (CMP_W'(i) <= cnt_x)) begin
        cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
      end else if (sh_dn && (i < CAPACITY - 1) && (CMP_W'(i) >= pos_x)
                   && (CMP_W'(i + 1) < cnt_x)) begin
        cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  // Capture the accepted request.
  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_req;
  end

  // Update cells and result on execute.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) cell_r[i] <= cell_nxt[i];
      rsp_r.status     <= status;
      rsp_r.entry_out  <= DATA_W'(rd_data);
      rsp_r.fill_count <= FILL_W'(count_nxt);
    end
  end

  // Limit register and count; a limit write clears the count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_W'(16);
      count_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_rsp = rsp_r;

endmodule

@@ design/bale_checker.sv @@
// Checker: port-level assertions for the array list engine, bound to the top.
module bale_checker
  import bale_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input bale_rsp_t out_rsp
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // No result right after reset.
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // Failed requests return no entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status != ST_OK) |-> (out_rsp.entry_out == '0))
    else $error("entry returned on failed request");

  // An empty report comes only with an empty list.
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_EMPTY) |-> (out_rsp.fill_count == '0))
    else $error("empty status with nonzero count");

  // Count never exceeds the built size.
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.fill_count <= FILL_W'(CAPACITY)))
    else $error("fill count above capacity");

endmodule

bind bounded_array_list_engine_unit bale_checker u_bale_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);
